// ----- rtl/crcg_pkg.sv -----
package crcg_pkg;

  localparam int COORD_W  = 32;
  localparam int MAG_W    = 32;
  localparam int LEN_W    = 31;
  localparam int REST_W   = 17;
  localparam int NORM_W   = 16;
  localparam int PEN_W    = 32;
  localparam int NM_W     = 31;              // normalized component magnitude
  localparam int SUM_W    = 68;              // radicand width of both square roots
  localparam int ROOT_W   = SUM_W / 2;
  localparam int T_W      = 64;
  localparam int DEN_W    = 32;
  localparam int DIV_Q_W  = 15;              // quotient never exceeds 16384
  localparam int NUM_W    = NM_W + DIV_Q_W;  // (mag << 14) + r/2

  localparam logic [REST_W-1:0] REST_ONE = REST_W'(65536);

  // front stages + root steps + post stage + divide steps + output register
  localparam int FRONT_LAT = 6;
  localparam int LATENCY   = FRONT_LAT + ROOT_W + 1 + DIV_Q_W + 1;

  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  max_len;
    logic [REST_W-1:0] rest;
    logic [2:0]        neg;
    logic              zero;
    logic              reach;
    logic              stretched;
  } link_side_t;

  typedef struct packed {
    link_side_t                side;
    logic [SUM_W-1:0]          s;
    logic [T_W-1:0]            t;
    logic [2:0][NM_W-1:0]      nm;
  } front_out_t;

  typedef struct packed {
    logic              contact;
    logic [PEN_W-1:0]  pen;
    logic [REST_W-1:0] rest;
    logic [2:0]        neg;
    logic              nz;
  } div_side_t;

endpackage

// ----- rtl/crcg_front.sv -----
module crcg_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic                                  in_func,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_x,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_y,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_z,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_x,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_y,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_z,
  input  logic        [crcg_pkg::LEN_W-1:0]     in_max_length,
  input  logic        [crcg_pkg::REST_W-1:0]    in_restitution_in,
  output logic                                  out_vld,
  output crcg_pkg::front_out_t                  out_data
);
  import crcg_pkg::*;

  // stage 1: capture
  logic                      vld1_r;
  logic                      func1_r;
  logic [COORD_W-1:0]        p1_r [3];
  logic [COORD_W-1:0]        p2_r [3];
  logic [LEN_W-1:0]          len1_r;
  logic [REST_W-1:0]         rest1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    func1_r <= in_func;
    p1_r[0] <= in_p1_x;
    p1_r[1] <= in_p1_y;
    p1_r[2] <= in_p1_z;
    p2_r[0] <= in_p2_x;
    p2_r[1] <= in_p2_y;
    p2_r[2] <= in_p2_z;
    len1_r  <= in_max_length;
    rest1_r <= in_restitution_in;
  end

  // stage 2: direction magnitudes and signs, restitution clamped to one
  logic [MAG_W-1:0] mag2_nxt [3];
  logic [2:0]       neg2_nxt;
  link_side_t       side2_nxt;
  logic             vld2_r;
  logic [MAG_W-1:0] mag2_r [3];
  link_side_t       side2_r;

  always_comb begin
    logic [COORD_W:0] d;
    logic [COORD_W:0] a;
    for (int i = 0; i < 3; i++) begin
      d = {p2_r[i][COORD_W-1], p2_r[i]} - {p1_r[i][COORD_W-1], p1_r[i]};
      a = d[COORD_W] ? (~d + 1'b1) : d;
      neg2_nxt[i] = d[COORD_W];
      mag2_nxt[i] = a[MAG_W-1:0];
    end
    side2_nxt           = '0;
    side2_nxt.func      = func1_r;
    side2_nxt.max_len   = len1_r;
    side2_nxt.rest      = (rest1_r > REST_ONE) ? REST_ONE : rest1_r;
    side2_nxt.neg       = neg2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    mag2_r  <= mag2_nxt;
    side2_r <= side2_nxt;
  end

  // stage 3: squares, length squared, leading-one search
  logic [2*MAG_W-1:0]   sq3_nxt [3];
  logic [2*LEN_W-1:0]   mm3_nxt;
  logic                 shr3_nxt;
  logic [4:0]           shl3_nxt;
  link_side_t           side3_nxt;
  logic                 vld3_r;
  logic [2*MAG_W-1:0]   sq3_r [3];
  logic [2*LEN_W-1:0]   mm3_r;
  logic [MAG_W-1:0]     mag3_r [3];
  logic                 shr3_r;
  logic [4:0]           shl3_r;
  link_side_t           side3_r;

  always_comb begin
    logic [MAG_W-1:0] big;
    logic [4:0]       pos;
    for (int i = 0; i < 3; i++) begin
      sq3_nxt[i] = (2*MAG_W)'(mag2_r[i]) * (2*MAG_W)'(mag2_r[i]);
    end
    mm3_nxt = (2*LEN_W)'(side2_r.max_len) * (2*LEN_W)'(side2_r.max_len);
    big = (mag2_r[0] > mag2_r[1]) ? mag2_r[0] : mag2_r[1];
    big = (mag2_r[2] > big) ? mag2_r[2] : big;
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (big[i]) pos = 5'(i);
    end
    shr3_nxt       = big[MAG_W-1];
    shl3_nxt       = shr3_nxt ? 5'd0 : 5'(5'd30 - pos);
    side3_nxt      = side2_r;
    side3_nxt.zero = (big == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else        vld3_r <= vld2_r;
  end

  always_ff @(posedge clk) begin
    sq3_r   <= sq3_nxt;
    mm3_r   <= mm3_nxt;
    mag3_r  <= mag2_r;
    shr3_r  <= shr3_nxt;
    shl3_r  <= shl3_nxt;
    side3_r <= side3_nxt;
  end

  // stage 4: distance squared, contact tests, normalizing shift
  logic [SUM_W-1:0]     s4_nxt;
  logic [2:0][NM_W-1:0] nm4_nxt;
  link_side_t           side4_nxt;
  logic                 vld4_r;
  logic [SUM_W-1:0]     s4_r;
  logic [2:0][NM_W-1:0] nm4_r;
  link_side_t           side4_r;

  always_comb begin
    logic [MAG_W-1:0] sl;
    s4_nxt = SUM_W'(sq3_r[0]) + SUM_W'(sq3_r[1]) + SUM_W'(sq3_r[2]);
    for (int i = 0; i < 3; i++) begin
      sl = mag3_r[i] << shl3_r;
      nm4_nxt[i] = shr3_r ? mag3_r[i][MAG_W-1:1] : sl[NM_W-1:0];
    end
    side4_nxt           = side3_r;
    side4_nxt.reach     = (s4_nxt >= SUM_W'(mm3_r));
    side4_nxt.stretched = (s4_nxt >  SUM_W'(mm3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld4_r <= 1'b0;
    else        vld4_r <= vld3_r;
  end

  always_ff @(posedge clk) begin
    s4_r    <= s4_nxt;
    nm4_r   <= nm4_nxt;
    side4_r <= side4_nxt;
  end

  // stage 5: squares of the normalized components
  logic [2*NM_W-1:0]    tsq5_r [3];
  logic                 vld5_r;
  logic [SUM_W-1:0]     s5_r;
  logic [2:0][NM_W-1:0] nm5_r;
  link_side_t           side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld5_r <= 1'b0;
    else        vld5_r <= vld4_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tsq5_r[i] <= (2*NM_W)'(nm4_r[i]) * (2*NM_W)'(nm4_r[i]);
    end
    s5_r    <= s4_r;
    nm5_r   <= nm4_r;
    side5_r <= side4_r;
  end

  // stage 6: normalized sum of squares
  front_out_t out_r;
  logic       vld6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld6_r <= 1'b0;
    else        vld6_r <= vld5_r;
  end

  always_ff @(posedge clk) begin
    out_r.side <= side5_r;
    out_r.s    <= s5_r;
    out_r.t    <= T_W'(tsq5_r[0]) + T_W'(tsq5_r[1]) + T_W'(tsq5_r[2]);
    out_r.nm   <= nm5_r;
  end

  assign out_vld  = vld6_r;
  assign out_data = out_r;

endmodule

// ----- rtl/crcg_sqrt.sv -----
module crcg_sqrt #(
  parameter int RAD_W  = crcg_pkg::SUM_W,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);
  localparam int RT_W  = RAD_W / 2;
  localparam int REM_W = RT_W + 2;

  // one result bit per stage, restoring digit recurrence
  logic              vld_r  [RT_W];
  logic [REM_W-1:0]  rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [RAD_W-1:0]  rad_r  [RT_W];
  logic [SIDE_W-1:0] side_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic              vld_p;
    logic [REM_W-1:0]  rem_p;
    logic [RT_W-1:0]   root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [SIDE_W-1:0] side_p;
    logic [REM_W-1:0]  remx;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      remx  = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      trial = {root_p, 2'b01};
      ge    = (remx >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vld_p;
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (remx - trial) : remx;
      root_r[k] <= {root_p[RT_W-2:0], ge};
      rad_r[k]  <= rad_p << 2;
      side_r[k] <= side_p;
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_side = side_r[RT_W-1];

endmodule

// ----- rtl/crcg_div.sv -----
module crcg_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_vld,
  input  logic [2:0][crcg_pkg::NUM_W-1:0]             in_num,
  input  logic [crcg_pkg::DEN_W-1:0]                  in_den,
  input  logic [SIDE_W-1:0]                           in_side,
  output logic                                        out_vld,
  output logic [2:0][crcg_pkg::DIV_Q_W-1:0]           out_quo,
  output logic [SIDE_W-1:0]                           out_side
);
  import crcg_pkg::*;

  // three lanes share the divisor; one quotient bit per stage
  logic                         vld_r  [DIV_Q_W];
  logic [2:0][DEN_W-1:0]        rem_r  [DIV_Q_W];
  logic [2:0][DIV_Q_W-1:0]      low_r  [DIV_Q_W];
  logic [2:0][DIV_Q_W-1:0]      quo_r  [DIV_Q_W];
  logic [DEN_W-1:0]             den_r  [DIV_Q_W];
  logic [SIDE_W-1:0]            side_r [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic                    vld_p;
    logic [2:0][DEN_W-1:0]   rem_p;
    logic [2:0][DIV_Q_W-1:0] low_p;
    logic [2:0][DIV_Q_W-1:0] quo_p;
    logic [DEN_W-1:0]        den_p;
    logic [SIDE_W-1:0]       side_p;
    logic [2:0][DEN_W-1:0]   rem_nxt;
    logic [2:0][DIV_Q_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l] = DEN_W'(in_num[l][NUM_W-1:DIV_Q_W]);
        assign low_p[l] = in_num[l][DIV_Q_W-1:0];
      end
      assign vld_p  = in_vld;
      assign quo_p  = '0;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign low_p  = low_r[k-1];
      assign quo_p  = quo_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      logic [DEN_W:0] remx;
      logic           ge;
      for (int l = 0; l < 3; l++) begin
        remx       = {rem_p[l], low_p[l][DIV_Q_W-1]};
        ge         = (remx >= {1'b0, den_p});
        rem_nxt[l] = ge ? DEN_W'(remx - {1'b0, den_p}) : remx[DEN_W-1:0];
        quo_nxt[l] = {quo_p[l][DIV_Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vld_p;
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      for (int l = 0; l < 3; l++) low_r[k][l] <= low_p[l] << 1;
      den_r[k]  <= den_p;
      side_r[k] <= side_p;
    end
  end

  assign out_vld  = vld_r[DIV_Q_W-1];
  assign out_quo  = quo_r[DIV_Q_W-1];
  assign out_side = side_r[DIV_Q_W-1];

endmodule

// ----- rtl/cable_rod_contact_generator_top.sv -----
// Channel      Handshake          Ports
// ------------ ------------------ ----------------------------------------------
// command      start / busy       in_func, in_p1_*, in_p2_*, in_max_length,
//                                 in_restitution_in
// result       out_valid strobe   out_contact, out_normal_*, out_penetration,
//                                 out_restitution
//
// A transaction is taken on every edge with start high; busy is never raised,
// so one link enters per cycle.
// Each result passes through 6 front stages, 34 root steps, 1 depth stage,
// 15 divide steps and 1 output register; the two bit-per-stage square roots
// and the divider account for the root and divide steps.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are
// not reset. The result strobe lasts one cycle and cannot be held off.
module cable_rod_contact_generator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_func,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_x,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_y,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p1_z,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_x,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_y,
  input  logic signed [crcg_pkg::COORD_W-1:0]   in_p2_z,
  input  logic        [crcg_pkg::LEN_W-1:0]     in_max_length,
  input  logic        [crcg_pkg::REST_W-1:0]    in_restitution_in,
  output logic                                  out_valid,
  output logic                                  out_contact,
  output logic signed [crcg_pkg::NORM_W-1:0]    out_normal_x,
  output logic signed [crcg_pkg::NORM_W-1:0]    out_normal_y,
  output logic signed [crcg_pkg::NORM_W-1:0]    out_normal_z,
  output logic        [crcg_pkg::PEN_W-1:0]     out_penetration,
  output logic        [crcg_pkg::REST_W-1:0]    out_restitution
);
  import crcg_pkg::*;

  localparam int LSIDE_W = $bits(link_side_t);
  localparam int NSIDE_W = 3 * NM_W;
  localparam int DSIDE_W = $bits(div_side_t);

  // nothing ever stalls the pipe
  assign busy = 1'b0;

  logic       acc;
  assign acc = start & ~busy;

  // front: differences, squares, contact tests, normalization
  logic       fr_vld;
  front_out_t fr_data;

  crcg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (acc),
    .in_func           (in_func),
    .in_p1_x           (in_p1_x),
    .in_p1_y           (in_p1_y),
    .in_p1_z           (in_p1_z),
    .in_p2_x           (in_p2_x),
    .in_p2_y           (in_p2_y),
    .in_p2_z           (in_p2_z),
    .in_max_length     (in_max_length),
    .in_restitution_in (in_restitution_in),
    .out_vld           (fr_vld),
    .out_data          (fr_data)
  );

  // two roots side by side: distance and normal length
  logic                 sa_vld, sb_vld;
  logic [ROOT_W-1:0]    len_root, nrm_root;
  link_side_t           sa_side;
  logic [2:0][NM_W-1:0] sb_nm;

  crcg_sqrt #(.RAD_W(SUM_W), .SIDE_W(LSIDE_W)) u_sqrt_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_rad   (fr_data.s),
    .in_side  (fr_data.side),
    .out_vld  (sa_vld),
    .out_root (len_root),
    .out_side (sa_side)
  );

  crcg_sqrt #(.RAD_W(SUM_W), .SIDE_W(NSIDE_W)) u_sqrt_nrm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_rad   (SUM_W'(fr_data.t)),
    .in_side  (fr_data.nm),
    .out_vld  (sb_vld),
    .out_root (nrm_root),
    .out_side (sb_nm)
  );

  // depth stage: penetration, sign flip for a compressed rod, divide inputs
  div_side_t            ds_nxt;
  logic [2:0][NUM_W-1:0] num_nxt;
  logic                 ds_vld_r;
  div_side_t            ds_r;
  logic [2:0][NUM_W-1:0] num_r;
  logic [DEN_W-1:0]     den_r;

  always_comb begin
    logic             fwd;
    logic [ROOT_W-1:0] diff;
    fwd  = ~sa_side.func | sa_side.stretched;
    // cable with reach or stretched rod: len >= max_len; else len <= max_len
    diff = fwd ? (len_root - ROOT_W'(sa_side.max_len))
               : (ROOT_W'(sa_side.max_len) - len_root);
    ds_nxt.contact = sa_side.func | sa_side.reach;
    ds_nxt.pen     = (diff[ROOT_W-1:PEN_W] != '0) ? '1 : diff[PEN_W-1:0];
    ds_nxt.rest    = sa_side.func ? '0 : sa_side.rest;
    ds_nxt.neg     = fwd ? sa_side.neg : ~sa_side.neg;
    ds_nxt.nz      = sa_side.zero | ~ds_nxt.contact;
    if (!ds_nxt.contact) begin
      ds_nxt.pen  = '0;
      ds_nxt.rest = '0;
    end
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = NUM_W'({sb_nm[i], 14'd0}) + NUM_W'(nrm_root[DEN_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ds_vld_r <= 1'b0;
    else        ds_vld_r <= sa_vld & sb_vld;
  end

  always_ff @(posedge clk) begin
    ds_r  <= ds_nxt;
    num_r <= num_nxt;
    den_r <= nrm_root[DEN_W-1:0];
  end

  // rounded component / normal length
  logic                    dv_vld;
  logic [2:0][DIV_Q_W-1:0] quo;
  div_side_t               dv_side;

  crcg_div #(.SIDE_W(DSIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ds_vld_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .in_side  (ds_r),
    .out_vld  (dv_vld),
    .out_quo  (quo),
    .out_side (dv_side)
  );

  // output register
  logic [NORM_W-1:0] nrm_nxt [3];
  logic              out_valid_r;
  logic              contact_r;
  logic [NORM_W-1:0] nrm_r [3];
  logic [PEN_W-1:0]  pen_r;
  logic [REST_W-1:0] rest_r;

  always_comb begin
    logic [NORM_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = NORM_W'(quo[i]);
      if (dv_side.nz)          nrm_nxt[i] = '0;
      else if (dv_side.neg[i]) nrm_nxt[i] = ~q + 1'b1;
      else                     nrm_nxt[i] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    contact_r <= dv_side.contact;
    nrm_r     <= nrm_nxt;
    pen_r     <= dv_side.pen;
    rest_r    <= dv_side.rest;
  end

  assign out_valid       = out_valid_r;
  assign out_contact     = contact_r;
  assign out_normal_x    = nrm_r[0];
  assign out_normal_y    = nrm_r[1];
  assign out_normal_z    = nrm_r[2];
  assign out_penetration = pen_r;
  assign out_restitution = rest_r;

endmodule

// ----- rtl/crcg_checker.sv -----
module crcg_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic                                  out_contact,
  input logic signed [crcg_pkg::NORM_W-1:0]    out_normal_x,
  input logic signed [crcg_pkg::NORM_W-1:0]    out_normal_y,
  input logic signed [crcg_pkg::NORM_W-1:0]    out_normal_z,
  input logic        [crcg_pkg::PEN_W-1:0]     out_penetration,
  input logic        [crcg_pkg::REST_W-1:0]    out_restitution
);
  import crcg_pkg::*;

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching command");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  a_slack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_contact) |-> (out_normal_x == '0 && out_normal_y == '0 &&
      out_normal_z == '0 && out_penetration == '0 && out_restitution == '0))
    else $error("slack cable result not cleared");

  a_rest_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_restitution <= REST_ONE))
    else $error("restitution above one");

endmodule

bind cable_rod_contact_generator_top crcg_checker u_crcg_checker (.*);
